/* rtl/trle_pkg.sv */
// Shared types and constants for the TGA RLE pixel decoder.
// Used by the stream interface, the config registers, the decode core and the top level.
package trle_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_REG_W  = 13;
  localparam int COORD_W    = 12;
  localparam int PIXEL_W    = 32;
  localparam int LEN_W      = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_BIT4     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_BIT5     = 3'd5;

  // Packet header: bit 7 marks a run packet, low seven bits hold count - 1
  localparam int               HDR_RUN_BIT = 7;
  localparam logic [6:0]       HDR_COUNT_MASK = 7'h7f;
  localparam logic [PIXEL_W-1:0] PIXEL_INIT = 32'hffff_ffff;

  typedef struct packed {
    logic                 rle_mode;
    logic                 alpha_present;
    logic [DIM_REG_W-1:0] image_width;
    logic [DIM_REG_W-1:0] image_height;
    logic                 descriptor_bit4;
    logic                 descriptor_bit5;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [COORD_W-1:0] dest_row;
    logic [COORD_W-1:0] first_column;
    logic [LEN_W-1:0]   run_length;
    logic               descending;
    logic               run_truncated;
    logic               image_done;
  } out_req_t;

endpackage

/* rtl/trle_stream_if.sv */
// Valid/ready stream interface carrying one request payload.
// Payload type comes from trle_pkg.
interface trle_stream_if #(
  parameter type payload_t = trle_pkg::in_req_t
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/trle_cfg_regs.sv */
// Configuration register file of the TGA RLE pixel decoder.
// Depends on trle_pkg for register indexes and the cfg_t struct.
module trle_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [trle_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trle_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output trle_pkg::cfg_t                      cfg_o
);

  trle_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        trle_pkg::CFG_RLE_MODE:      cfg_d.rle_mode        = cfg_data_i[0];
        trle_pkg::CFG_ALPHA_PRESENT: cfg_d.alpha_present   = cfg_data_i[0];
        trle_pkg::CFG_IMAGE_WIDTH:   cfg_d.image_width     = cfg_data_i;
        trle_pkg::CFG_IMAGE_HEIGHT:  cfg_d.image_height    = cfg_data_i;
        trle_pkg::CFG_DESC_BIT4:     cfg_d.descriptor_bit4 = cfg_data_i[0];
        trle_pkg::CFG_DESC_BIT5:     cfg_d.descriptor_bit5 = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_mode        <= 1'b0;
      cfg_q.alpha_present   <= 1'b0;
      cfg_q.image_width     <= trle_pkg::DIM_REG_W'(1);
      cfg_q.image_height    <= trle_pkg::DIM_REG_W'(1);
      cfg_q.descriptor_bit4 <= 1'b0;
      cfg_q.descriptor_bit5 <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/trle_core.sv */
// Byte decode core: packet, pixel and position state plus the one-byte step logic.
// Depends on trle_pkg for cfg_t, out_req_t and header constants.
module trle_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trle_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output trle_pkg::out_req_t  res_o
);

  localparam int CNT_W = $clog2(MAX_DIMENSION + 1);
  localparam int CW    = (CNT_W > trle_pkg::DIM_REG_W) ? CNT_W : trle_pkg::DIM_REG_W;
  localparam logic [CW-1:0] MAX_DIM = CW'(MAX_DIMENSION);

  function automatic logic [CW-1:0] clamp_dim(logic [trle_pkg::DIM_REG_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (v == '0) clamp_dim = CW'(1);
    else if (e > MAX_DIM) clamp_dim = MAX_DIM;
    else clamp_dim = e;
  endfunction

  logic [trle_pkg::PIXEL_W-1:0] acc_q, acc_d, acc_new;
  logic [1:0]                   bip_q, bip_d, last_byte;
  logic [trle_pkg::LEN_W-1:0]   rem_q, rem_d, rem_dec;
  logic                         is_run_q, is_run_d;
  logic [CW-1:0]                col_q, col_d, row_q, row_d;
  logic                         fin_q, fin_d;

  logic [CW-1:0] w, h, left, len_ext, row0, rowv, colv, row_inc;
  logic          trunc, done;

  assign w         = clamp_dim(cfg_i.image_width);
  assign h         = clamp_dim(cfg_i.image_height);
  assign last_byte = cfg_i.alpha_present ? 2'd3 : 2'd2;
  assign row_inc   = row_q + CW'(1);

  always_comb begin
    acc_new = acc_q;
    acc_new[{bip_q, 3'b000} +: 8] = byte_i;
  end

  always_comb begin
    acc_d    = acc_q;
    bip_d    = bip_q;
    rem_d    = rem_q;
    is_run_d = is_run_q;
    col_d    = col_q;
    row_d    = row_q;
    fin_d    = fin_q;
    rem_dec  = rem_q - 8'd1;
    left     = (col_q < w) ? (w - col_q) : CW'(1);
    trunc    = 1'b0;
    done     = 1'b0;
    len_ext  = CW'(1);
    row0     = cfg_i.descriptor_bit4 ? row_q : (h - CW'(1) - row_q);
    rowv     = cfg_i.descriptor_bit5 ? (h - CW'(1) - row0) : row0;
    if (col_q >= w) colv = cfg_i.descriptor_bit4 ? '0 : col_q;
    else colv = cfg_i.descriptor_bit4 ? (w - CW'(1) - col_q) : col_q;
    res_valid_o = 1'b0;

    if (fire_i && !fin_q) begin
      if (row_q >= h) begin
        fin_d = 1'b1;
      end else if (cfg_i.rle_mode && rem_q == '0) begin
        // packet header
        is_run_d = byte_i[trle_pkg::HDR_RUN_BIT];
        rem_d    = {1'b0, byte_i[6:0] & trle_pkg::HDR_COUNT_MASK} + 8'd1;
        bip_d    = '0;
        acc_d    = trle_pkg::PIXEL_INIT;
      end else if (bip_q < last_byte) begin
        acc_d = acc_new;
        bip_d = bip_q + 2'd1;
      end else begin
        if (cfg_i.rle_mode && is_run_q) begin
          len_ext = CW'(rem_q);
          if (len_ext > left) begin
            len_ext = left;
            trunc   = 1'b1;
          end
          rem_d = '0;
        end else if (cfg_i.rle_mode) begin
          rem_d = rem_dec;
          // raw packet hitting the row end is cut there
          if (left == CW'(1) && rem_dec != '0) begin
            trunc = 1'b1;
            rem_d = '0;
          end
        end
        if (len_ext >= left) begin
          col_d = '0;
          row_d = row_inc;
          if (row_inc >= h) begin
            fin_d = 1'b1;
            done  = 1'b1;
          end
        end else begin
          col_d = col_q + len_ext;
        end
        acc_d       = trle_pkg::PIXEL_INIT;
        bip_d       = '0;
        res_valid_o = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.pixel_value   = acc_new;
    res_o.dest_row      = rowv[trle_pkg::COORD_W-1:0];
    res_o.first_column  = colv[trle_pkg::COORD_W-1:0];
    res_o.run_length    = len_ext[trle_pkg::LEN_W-1:0];
    res_o.descending    = cfg_i.descriptor_bit4;
    res_o.run_truncated = trunc;
    res_o.image_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= trle_pkg::PIXEL_INIT;
      bip_q    <= '0;
      rem_q    <= '0;
      is_run_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      fin_q    <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      bip_q    <= bip_d;
      rem_q    <= rem_d;
      is_run_q <= is_run_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fin_q    <= fin_d;
    end
  end

endmodule

/* rtl/tga_rle_pixel_decoder_top.sv */
// TGA truecolor pixel-data decoder (image types 2 and 10), top level.
// Depends on trle_pkg, trle_stream_if, trle_cfg_regs and trle_core.
//
// Usage: software parses and skips the TGA header, programs the six config
// registers while the block is idle, then streams the pixel-data bytes (packet
// headers included) one per input request. The block takes one byte per clock
// cycle while the result register can move: a byte lands in an input register,
// then, once the result register can move, the decode core updates its
// packet/pixel/position counters and, when a pixel or a run packet completes,
// loads one output request into the result register. A result is registered:
// the byte completing it passes the input register, then the result register.
// Each result is a run: pixel value (alpha forced to 0xff for 24-bit pixels),
// final row and first column with both orientation flips already applied,
// length 1..128, direction, a flag for a packet cut at the row end, and a flag
// on the image's last pixel. Bytes after the last pixel are swallowed until
// reset. Both sides stall independently; the input register takes a byte while
// it is empty or while the result register can move on that cycle.
module tga_rle_pixel_decoder_top #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  trle_stream_if.sink                     in_i,
  trle_stream_if.source                   out_o,
  input  logic                            cfg_we_i,
  input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  trle_pkg::cfg_t     cfg;
  trle_pkg::out_req_t res;
  logic               res_valid;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  // result register
  logic               out_valid_q, out_valid_d;
  trle_pkg::out_req_t out_q;

  logic out_free, s1_fire, in_acc;

  trle_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  trle_core #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (s1_fire),
    .byte_i      (s1_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register can take a new request when empty or being drained.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = in_acc || (s1_valid_q && !s1_fire);
    out_valid_d = out_free ? (s1_fire && res_valid) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.payload.data_byte;
    end
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
